// ----- hdl/shp_pkg.sv -----
// Shared types and constants for the ServerHello parser.
// No dependencies.
package shp_pkg;

    typedef enum logic [3:0] {
        PH_VER     = 4'd0,
        PH_RAND    = 4'd1,
        PH_SIDLEN  = 4'd2,
        PH_SID     = 4'd3,
        PH_SUITE   = 4'd4,
        PH_COMP    = 4'd5,
        PH_EXTLEN  = 4'd6,
        PH_EXTHDR  = 4'd7,
        PH_EXTBODY = 4'd8,
        PH_DONE    = 4'd9
    } phase_t;

    localparam logic [1:0] KIND_RANDOM  = 2'd0;
    localparam logic [1:0] KIND_SID     = 2'd1;
    localparam logic [1:0] KIND_KEY     = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    localparam logic [15:0] EXT_SUPPORTED_VERSIONS = 16'h002B;
    localparam logic [15:0] EXT_KEY_SHARE          = 16'h0033;
    localparam logic [15:0] KEY_BYTES              = 16'd32;
    localparam logic [15:0] RANDOM_BYTES           = 16'd32;
    localparam logic [16:0] RETRY_MIN_OFFSET       = 17'd34;
    localparam logic [7:0]  MAX_SID_LEN            = 8'd32;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  byte_index;
        logic [7:0]  data_byte;
        logic        ok;
        logic        is_retry_request;
        logic [5:0]  session_id_length;
        logic [15:0] suite_code;
        logic [7:0]  comp_method;
        logic [15:0] sel_version;
        logic [15:0] key_group;
        logic        key_present;
        logic        final_res;
    } result_t;

    function automatic logic [7:0] retry_magic(input logic [4:0] idx);
        logic [7:0] v;
        case (idx)
            5'd0:  v = 8'hCF;  5'd1:  v = 8'h21;  5'd2:  v = 8'hAD;  5'd3:  v = 8'h74;
            5'd4:  v = 8'hE5;  5'd5:  v = 8'h9A;  5'd6:  v = 8'h61;  5'd7:  v = 8'h11;
            5'd8:  v = 8'hBE;  5'd9:  v = 8'h1D;  5'd10: v = 8'h8C;  5'd11: v = 8'h02;
            5'd12: v = 8'h1E;  5'd13: v = 8'h65;  5'd14: v = 8'hB8;  5'd15: v = 8'h91;
            5'd16: v = 8'hC2;  5'd17: v = 8'hA2;  5'd18: v = 8'h11;  5'd19: v = 8'h16;
            5'd20: v = 8'h7A;  5'd21: v = 8'hBB;  5'd22: v = 8'h8C;  5'd23: v = 8'h5E;
            5'd24: v = 8'h07;  5'd25: v = 8'h9E;  5'd26: v = 8'h09;  5'd27: v = 8'hE2;
            5'd28: v = 8'hC8;  5'd29: v = 8'hA8;  5'd30: v = 8'h33;  5'd31: v = 8'h9C;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/server_hello_parser.sv -----
// ServerHello body parser: byte-wise field walk with a small result queue.
// Depends on shp_pkg.
//
//  port group  dir  word
//  s_*         in   one body byte plus end_of_message flag
//  m_*         out  one emitted byte (random, session id, key) or the summary
//
//  One byte is taken per cycle while s_ready is high; parser state updates in the accepting cycle.
//  A byte can yield two words (emitted byte plus summary), so a 4-entry queue
//  sits at the output and s_ready drops while it holds more than two words.
//  A word is written into the queue when its byte is accepted and shows on m_* once the words ahead of it are popped.
//  Synchronous active-low reset; no clearing pass. State returns to reset
//  after each end_of_message byte.
module server_hello_parser import shp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [4:0]  m_byte_index,
    output logic [7:0]  m_data_byte,
    output logic        m_ok,
    output logic        m_is_retry_request,
    output logic [5:0]  m_session_id_length,
    output logic [15:0] m_suite_code,
    output logic [7:0]  m_comp_method,
    output logic [15:0] m_sel_version,
    output logic [15:0] m_key_group,
    output logic        m_key_present,
    output logic        m_final_res
);

    phase_t      phase_reg, phase_next;
    logic [16:0] offset_reg, offset_next;
    logic [15:0] count_reg, count_next;
    logic [16:0] ext_end_reg, ext_end_next;
    logic [15:0] ext_kind_reg, ext_kind_next;
    logic [15:0] ext_len_reg, ext_len_next;
    logic [15:0] key_len_reg, key_len_next;
    logic        magic_reg, magic_next;
    logic [5:0]  sid_len_reg, sid_len_next;
    logic [15:0] suite_reg, suite_next;
    logic [7:0]  compress_reg, compress_next;
    logic [15:0] version_reg, version_next;
    logic [15:0] group_reg, group_next;
    logic        key_seen_reg, key_seen_next;
    logic [7:0]  high_reg, high_next;
    logic        error_reg, error_next;

    logic        emit_v;
    logic [1:0]  emit_kind;
    logic [4:0]  emit_idx;
    logic [15:0] pos_key;
    logic        accept;
    result_t     first_word, summary_word;

    result_t     queue_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   fill_reg;
    logic        push_first, push_second, pop;
    logic [QAW:0] push_cnt;

    assign s_ready = (fill_reg <= (QAW+1)'(QDEPTH - 2));
    assign accept  = s_valid && s_ready;

    always_comb begin
        phase_next    = phase_reg;
        offset_next   = offset_reg;
        count_next    = count_reg;
        ext_end_next  = ext_end_reg;
        ext_kind_next = ext_kind_reg;
        ext_len_next  = ext_len_reg;
        key_len_next  = key_len_reg;
        magic_next    = magic_reg;
        sid_len_next  = sid_len_reg;
        suite_next    = suite_reg;
        compress_next = compress_reg;
        version_next  = version_reg;
        group_next    = group_reg;
        key_seen_next = key_seen_reg;
        high_next     = high_reg;
        error_next    = error_reg;
        emit_v        = 1'b0;
        emit_kind     = KIND_RANDOM;
        emit_idx      = count_reg[4:0];
        pos_key       = count_reg - 16'd4;

        if (phase_reg != PH_DONE) begin
            offset_next = offset_reg + 17'd1;
        end

        case (phase_reg)
            PH_VER: begin
                count_next = count_reg + 16'd1;
                if (count_next == 16'd2) begin
                    count_next = '0;
                    phase_next = PH_RAND;
                end
            end
            PH_RAND: begin
                emit_v    = 1'b1;
                emit_kind = KIND_RANDOM;
                if (s_byte_value != retry_magic(count_reg[4:0])) begin
                    magic_next = 1'b0;
                end
                count_next = count_reg + 16'd1;
                if (count_next == RANDOM_BYTES) begin
                    count_next = '0;
                    phase_next = PH_SIDLEN;
                end
            end
            PH_SIDLEN: begin
                if (s_byte_value > MAX_SID_LEN) begin
                    error_next = 1'b1;
                    phase_next = PH_DONE;
                end else begin
                    sid_len_next = s_byte_value[5:0];
                    count_next   = '0;
                    phase_next   = (s_byte_value != 8'd0) ? PH_SID : PH_SUITE;
                end
            end
            PH_SID: begin
                emit_v     = 1'b1;
                emit_kind  = KIND_SID;
                count_next = count_reg + 16'd1;
                if (count_next >= {10'd0, sid_len_reg}) begin
                    count_next = '0;
                    phase_next = PH_SUITE;
                end
            end
            PH_SUITE: begin
                if (count_reg == 16'd0) begin
                    high_next  = s_byte_value;
                    count_next = 16'd1;
                end else begin
                    suite_next = {high_reg, s_byte_value};
                    count_next = '0;
                    phase_next = PH_COMP;
                end
            end
            PH_COMP: begin
                compress_next = s_byte_value;
                phase_next    = PH_EXTLEN;
            end
            PH_EXTLEN: begin
                if (count_reg == 16'd0) begin
                    high_next  = s_byte_value;
                    count_next = 16'd1;
                end else begin
                    ext_end_next = offset_next + {1'b0, high_reg, s_byte_value};
                    count_next   = '0;
                    phase_next   = ({high_reg, s_byte_value} != 16'd0) ? PH_EXTHDR : PH_DONE;
                end
            end
            PH_EXTHDR: begin
                if (count_reg == 16'd0 || count_reg == 16'd2) begin
                    high_next  = s_byte_value;
                    count_next = count_reg + 16'd1;
                end else if (count_reg == 16'd1) begin
                    ext_kind_next = {high_reg, s_byte_value};
                    count_next    = 16'd2;
                end else begin
                    ext_len_next = {high_reg, s_byte_value};
                    count_next   = '0;
                    if (ext_len_next == 16'd0) begin
                        if (ext_kind_reg == EXT_KEY_SHARE) begin
                            error_next = 1'b1;
                            phase_next = PH_DONE;
                        end else begin
                            phase_next = (offset_next >= ext_end_reg) ? PH_DONE : PH_EXTHDR;
                        end
                    end else begin
                        phase_next = PH_EXTBODY;
                    end
                end
            end
            PH_EXTBODY: begin
                if (ext_kind_reg == EXT_SUPPORTED_VERSIONS) begin
                    if (count_reg == 16'd0) begin
                        high_next = s_byte_value;
                    end else if (count_reg == 16'd1) begin
                        version_next = {high_reg, s_byte_value};
                    end
                end else if (ext_kind_reg == EXT_KEY_SHARE) begin
                    if (count_reg == 16'd0 || count_reg == 16'd2) begin
                        high_next = s_byte_value;
                    end else if (count_reg == 16'd1) begin
                        group_next = {high_reg, s_byte_value};
                    end else if (count_reg == 16'd3) begin
                        key_len_next = {high_reg, s_byte_value};
                    end else if (count_reg < 16'd4 + KEY_BYTES && key_len_reg == KEY_BYTES &&
                                 ext_len_reg >= 16'd4 + KEY_BYTES) begin
                        emit_v    = 1'b1;
                        emit_kind = KIND_KEY;
                        emit_idx  = pos_key[4:0];
                        if (count_reg == 16'd3 + KEY_BYTES) begin
                            key_seen_next = 1'b1;
                        end
                    end
                end
                count_next = count_reg + 16'd1;
                if (count_next >= ext_len_reg) begin
                    if (ext_kind_reg == EXT_KEY_SHARE && ext_len_reg < 16'd4) begin
                        error_next = 1'b1;
                        phase_next = PH_DONE;
                    end else begin
                        count_next = '0;
                        phase_next = (offset_next >= ext_end_reg) ? PH_DONE : PH_EXTHDR;
                    end
                end
            end
            default: begin
            end
        endcase

        if (s_end_of_message && phase_next != PH_DONE) begin
            error_next = 1'b1;
        end
    end

    always_comb begin
        first_word            = '0;
        first_word.kind       = emit_kind;
        first_word.byte_index = emit_idx;
        first_word.data_byte  = s_byte_value;

        summary_word                   = '0;
        summary_word.kind              = KIND_SUMMARY;
        summary_word.ok                = !error_next;
        summary_word.is_retry_request  = (offset_next >= RETRY_MIN_OFFSET) && magic_next;
        summary_word.session_id_length = sid_len_next;
        summary_word.suite_code        = suite_next;
        summary_word.comp_method       = compress_next;
        summary_word.sel_version       = version_next;
        summary_word.key_group         = group_next;
        summary_word.key_present       = key_seen_next;
        summary_word.final_res         = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_end_of_message)) begin
            phase_reg    <= PH_VER;
            offset_reg   <= '0;
            count_reg    <= '0;
            ext_end_reg  <= '0;
            ext_kind_reg <= '0;
            ext_len_reg  <= '0;
            key_len_reg  <= '0;
            magic_reg    <= 1'b1;
            sid_len_reg  <= '0;
            suite_reg    <= '0;
            compress_reg <= '0;
            version_reg  <= '0;
            group_reg    <= '0;
            key_seen_reg <= 1'b0;
            high_reg     <= '0;
            error_reg    <= 1'b0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            offset_reg   <= offset_next;
            count_reg    <= count_next;
            ext_end_reg  <= ext_end_next;
            ext_kind_reg <= ext_kind_next;
            ext_len_reg  <= ext_len_next;
            key_len_reg  <= key_len_next;
            magic_reg    <= magic_next;
            sid_len_reg  <= sid_len_next;
            suite_reg    <= suite_next;
            compress_reg <= compress_next;
            version_reg  <= version_next;
            group_reg    <= group_next;
            key_seen_reg <= key_seen_next;
            high_reg     <= high_next;
            error_reg    <= error_next;
        end
    end

    // result queue: up to two words pushed, one popped per cycle while m_ready is high
    assign push_first  = accept && (emit_v || s_end_of_message);
    assign push_second = accept && emit_v && s_end_of_message;
    assign pop         = m_valid && m_ready;
    assign push_cnt    = (QAW+1)'(push_first) + (QAW+1)'(push_second);

    always_ff @(posedge aclk) begin
        if (push_first) begin
            queue_reg[wr_ptr_reg] <= emit_v ? first_word : summary_word;
        end
        if (push_second) begin
            queue_reg[wr_ptr_reg + QAW'(1)] <= summary_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push_cnt[QAW-1:0];
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            fill_reg <= fill_reg + push_cnt - (QAW+1)'(pop);
        end
    end

    assign m_valid             = (fill_reg != '0);
    assign m_kind              = queue_reg[rd_ptr_reg].kind;
    assign m_byte_index        = queue_reg[rd_ptr_reg].byte_index;
    assign m_data_byte         = queue_reg[rd_ptr_reg].data_byte;
    assign m_ok                = queue_reg[rd_ptr_reg].ok;
    assign m_is_retry_request  = queue_reg[rd_ptr_reg].is_retry_request;
    assign m_session_id_length = queue_reg[rd_ptr_reg].session_id_length;
    assign m_suite_code        = queue_reg[rd_ptr_reg].suite_code;
    assign m_comp_method       = queue_reg[rd_ptr_reg].comp_method;
    assign m_sel_version       = queue_reg[rd_ptr_reg].sel_version;
    assign m_key_group         = queue_reg[rd_ptr_reg].key_group;
    assign m_key_present       = queue_reg[rd_ptr_reg].key_present;
    assign m_final_res         = queue_reg[rd_ptr_reg].final_res;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= (QAW+1)'(QDEPTH))
        else $error("result queue overflow");

    a_summary_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_end_of_message |=> fill_reg != '0)
        else $error("summary word not queued");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_end_of_message |=> phase_reg == PH_VER && offset_reg == '0)
        else $error("parser did not restart after end of message");

    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DONE && accept && !s_end_of_message |=> $stable(offset_reg))
        else $error("offset moved after parse finished");
`endif

endmodule

// ----- bench/server_hello_parser_test.sv -----
// Self-checking bench for server_hello_parser: random ServerHello bodies in, emitted
// bytes and summary words checked against a byte-level model of the parse.
// Depends on shp_pkg and hdl/server_hello_parser.sv.
`timescale 1ns / 100ps

import shp_pkg::*;

localparam logic [7:0] HRR_RANDOM [32] = '{
    8'hCF, 8'h21, 8'hAD, 8'h74, 8'hE5, 8'h9A, 8'h61, 8'h11,
    8'hBE, 8'h1D, 8'h8C, 8'h02, 8'h1E, 8'h65, 8'hB8, 8'h91,
    8'hC2, 8'hA2, 8'h11, 8'h16, 8'h7A, 8'hBB, 8'h8C, 8'h5E,
    8'h07, 8'h9E, 8'h09, 8'hE2, 8'hC8, 8'hA8, 8'h33, 8'h9C
};

class hello_results;
    result_t     due_words[$];
    int          mismatch_count;
    phase_t      phase;
    logic [16:0] offset;
    logic [16:0] list_end;
    logic [15:0] count;
    logic [15:0] ext_code;
    logic [15:0] ext_len;
    logic [15:0] key_len;
    logic        magic_ok;
    logic [5:0]  sid_len;
    logic [15:0] suite;
    logic [7:0]  compress;
    logic [15:0] version;
    logic [15:0] group;
    logic        key_done;
    logic [7:0]  hold;
    logic        failed;

    function new();
        mismatch_count = 0;
        clear();
    endfunction

    function void clear();
        phase = PH_VER;
        offset = '0;
        list_end = '0;
        count = '0;
        ext_code = '0;
        ext_len = '0;
        key_len = '0;
        magic_ok = 1'b1;
        sid_len = '0;
        suite = '0;
        compress = '0;
        version = '0;
        group = '0;
        key_done = 1'b0;
        hold = '0;
        failed = 1'b0;
    endfunction

    function void emit(logic [1:0] k, logic [4:0] idx, logic [7:0] d);
        result_t r;
        r = '0;
        r.kind = k;
        r.byte_index = idx;
        r.data_byte = d;
        due_words = {due_words, r};
    endfunction

    function void abort();
        failed = 1'b1;
        phase = PH_DONE;
    endfunction

    function void end_ext();
        count = '0;
        phase = (offset >= list_end) ? PH_DONE : PH_EXTHDR;
    endfunction

    // accepted input byte: advance the parse and queue the words it causes
    function void take_byte(logic [7:0] b, logic last);
        result_t     s;
        logic [15:0] slot;
        if (phase != PH_DONE) offset = offset + 17'd1;
        case (phase)
            PH_VER: begin
                count++;
                if (count == 16'd2) begin
                    count = '0;
                    phase = PH_RAND;
                end
            end
            PH_RAND: begin
                emit(KIND_RANDOM, count[4:0], b);
                if (b != HRR_RANDOM[count[4:0]]) magic_ok = 1'b0;
                count++;
                if (count == RANDOM_BYTES) begin
                    count = '0;
                    phase = PH_SIDLEN;
                end
            end
            PH_SIDLEN: begin
                if (b > MAX_SID_LEN) begin
                    abort();
                end else begin
                    sid_len = b[5:0];
                    count = '0;
                    phase = (b != 8'd0) ? PH_SID : PH_SUITE;
                end
            end
            PH_SID: begin
                emit(KIND_SID, count[4:0], b);
                count++;
                if (count >= {10'd0, sid_len}) begin
                    count = '0;
                    phase = PH_SUITE;
                end
            end
            PH_SUITE: begin
                if (count == 16'd0) begin
                    hold = b;
                    count = 16'd1;
                end else begin
                    suite = {hold, b};
                    count = '0;
                    phase = PH_COMP;
                end
            end
            PH_COMP: begin
                compress = b;
                phase = PH_EXTLEN;
            end
            PH_EXTLEN: begin
                if (count == 16'd0) begin
                    hold = b;
                    count = 16'd1;
                end else begin
                    list_end = offset + {1'b0, hold, b};
                    count = '0;
                    phase = ({hold, b} != 16'd0) ? PH_EXTHDR : PH_DONE;
                end
            end
            PH_EXTHDR: begin
                if (count == 16'd0 || count == 16'd2) begin
                    hold = b;
                    count++;
                end else if (count == 16'd1) begin
                    ext_code = {hold, b};
                    count = 16'd2;
                end else begin
                    ext_len = {hold, b};
                    count = '0;
                    if (ext_len == 16'd0) begin
                        if (ext_code == EXT_KEY_SHARE) abort();
                        else end_ext();
                    end else begin
                        phase = PH_EXTBODY;
                    end
                end
            end
            PH_EXTBODY: begin
                if (ext_code == EXT_SUPPORTED_VERSIONS) begin
                    if (count == 16'd0) hold = b;
                    else if (count == 16'd1) version = {hold, b};
                end else if (ext_code == EXT_KEY_SHARE) begin
                    if (count == 16'd0 || count == 16'd2) begin
                        hold = b;
                    end else if (count == 16'd1) begin
                        group = {hold, b};
                    end else if (count == 16'd3) begin
                        key_len = {hold, b};
                    end else if (count < 16'd4 + KEY_BYTES && key_len == KEY_BYTES &&
                                 ext_len >= 16'd4 + KEY_BYTES) begin
                        slot = count - 16'd4;
                        emit(KIND_KEY, slot[4:0], b);
                        if (count == 16'd3 + KEY_BYTES) key_done = 1'b1;
                    end
                end
                count++;
                if (count >= ext_len) begin
                    if (ext_code == EXT_KEY_SHARE && ext_len < 16'd4) abort();
                    else end_ext();
                end
            end
            default: ;
        endcase
        if (last) begin
            if (phase != PH_DONE) failed = 1'b1;
            s = '0;
            s.kind = KIND_SUMMARY;
            s.ok = !failed;
            s.is_retry_request = (offset >= RETRY_MIN_OFFSET) && magic_ok;
            s.session_id_length = sid_len;
            s.suite_code = suite;
            s.comp_method = compress;
            s.sel_version = version;
            s.key_group = group;
            s.key_present = key_done;
            s.final_res = 1'b1;
            due_words = {due_words, s};
            clear();
        end
    endfunction

    function string show(result_t r);
        return $sformatf({"kind=%0d idx=%0d data=%02h ok=%0d hrr=%0d sid_len=%0d suite=%04h ",
                          "comp=%02h ver=%04h group=%04h key=%0d final=%0d"},
                         r.kind, r.byte_index, r.data_byte, r.ok, r.is_retry_request,
                         r.session_id_length, r.suite_code, r.comp_method,
                         r.sel_version, r.key_group, r.key_present, r.final_res);
    endfunction

    function string diff(result_t w, result_t g);
        string s;
        s = "";
        if (g.kind !== w.kind) s = {s, " kind"};
        if (g.byte_index !== w.byte_index) s = {s, " byte_index"};
        if (g.data_byte !== w.data_byte) s = {s, " data_byte"};
        if (g.ok !== w.ok) s = {s, " ok"};
        if (g.is_retry_request !== w.is_retry_request) s = {s, " is_retry_request"};
        if (g.session_id_length !== w.session_id_length) s = {s, " session_id_length"};
        if (g.suite_code !== w.suite_code) s = {s, " suite_code"};
        if (g.comp_method !== w.comp_method) s = {s, " comp_method"};
        if (g.sel_version !== w.sel_version) s = {s, " sel_version"};
        if (g.key_group !== w.key_group) s = {s, " key_group"};
        if (g.key_present !== w.key_present) s = {s, " key_present"};
        if (g.final_res !== w.final_res) s = {s, " final_res"};
        return s;
    endfunction

    function void check_word(result_t got);
        result_t want;
        string   bad;
        if (due_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected word: %s", show(got));
            return;
        end
        want = due_words.pop_front();
        bad = diff(want, got);
        if (bad != "") begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("word mismatch in%s", bad);
                $display("  expected %s", show(want));
                $display("  actual   %s", show(got));
            end
        end
    endfunction
endclass

module server_hello_parser_test;

    typedef enum int {
        PLAN_RANDOM,
        PLAN_FULL,
        PLAN_LONG_SID,
        PLAN_SHORT_KEY,
        PLAN_EMPTY_KEY,
        PLAN_SHORT_LIST,
        PLAN_REPEAT,
        PLAN_CUT,
        PLAN_TRAILING,
        PLAN_ODD_KEY,
        PLAN_NOISE
    } plan_t;

    typedef enum int {
        SHAPE_VERSIONS,
        SHAPE_KEY,
        SHAPE_KEY_SHORT,
        SHAPE_KEY_EMPTY,
        SHAPE_KEY_ODD,
        SHAPE_OTHER
    } ext_shape_t;

    localparam int FIXED_PLANS  = 10;
    localparam int BYTE_TARGET  = 850;
    localparam int IDLE_PCT     = 22;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 20;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_value = 8'd0;
    logic        s_end_of_message = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [4:0]  m_byte_index;
    logic [7:0]  m_data_byte;
    logic        m_ok;
    logic        m_is_retry_request;
    logic [5:0]  m_session_id_length;
    logic [15:0] m_suite_code;
    logic [7:0]  m_comp_method;
    logic [15:0] m_sel_version;
    logic [15:0] m_key_group;
    logic        m_key_present;
    logic        m_final_res;

    result_t      word_seen;
    hello_results sb;
    bit           quiet = 1'b0;
    int           stall_cycles = 0;

    server_hello_parser dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_byte_value        (s_byte_value),
        .s_end_of_message    (s_end_of_message),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_kind              (m_kind),
        .m_byte_index        (m_byte_index),
        .m_data_byte         (m_data_byte),
        .m_ok                (m_ok),
        .m_is_retry_request  (m_is_retry_request),
        .m_session_id_length (m_session_id_length),
        .m_suite_code        (m_suite_code),
        .m_comp_method       (m_comp_method),
        .m_sel_version       (m_sel_version),
        .m_key_group         (m_key_group),
        .m_key_present       (m_key_present),
        .m_final_res         (m_final_res)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    assign word_seen = {m_kind, m_byte_index, m_data_byte, m_ok, m_is_retry_request,
                        m_session_id_length, m_suite_code, m_comp_method,
                        m_sel_version, m_key_group, m_key_present, m_final_res};

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_word(word_seen);
        m_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void push16(ref logic [7:0] q[$], input logic [15:0] v);
        q = {q, v[15:8], v[7:0]};
    endfunction

    function automatic void append_ext(input ext_shape_t shape, ref logic [7:0] q[$]);
        int          len;
        logic [15:0] klen;
        case (shape)
            SHAPE_VERSIONS: begin
                len = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 2;
                push16(q, EXT_SUPPORTED_VERSIONS);
                push16(q, 16'(len));
                if ($urandom_range(1) == 0) begin
                    push16(q, 16'h0304);
                    len = len - 2;
                end
                repeat (len) q = {q, 8'($urandom)};
            end
            SHAPE_KEY: begin
                len = 36 + (($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0);
                push16(q, EXT_KEY_SHARE);
                push16(q, 16'(len));
                push16(q, ($urandom_range(1) == 0) ? 16'h001D : 16'($urandom));
                push16(q, KEY_BYTES);
                repeat (len - 4) q = {q, 8'($urandom)};
            end
            SHAPE_KEY_SHORT: begin
                len = $urandom_range(1, 3);
                push16(q, EXT_KEY_SHARE);
                push16(q, 16'(len));
                repeat (len) q = {q, 8'($urandom)};
            end
            SHAPE_KEY_EMPTY: begin
                push16(q, EXT_KEY_SHARE);
                push16(q, 16'd0);
            end
            SHAPE_KEY_ODD: begin
                if ($urandom_range(1) == 0) begin
                    klen = KEY_BYTES;
                    len = $urandom_range(4, 35);
                end else begin
                    klen = 16'($urandom);
                    if (klen == KEY_BYTES) klen = klen + 16'd1;
                    len = $urandom_range(4, 40);
                end
                push16(q, EXT_KEY_SHARE);
                push16(q, 16'(len));
                push16(q, 16'($urandom));
                push16(q, klen);
                repeat (len - 4) q = {q, 8'($urandom)};
            end
            default: begin
                len = $urandom_range(0, 5);
                push16(q, 16'($urandom));
                push16(q, 16'(len));
                repeat (len) q = {q, 8'($urandom)};
            end
        endcase
    endfunction

    function automatic ext_shape_t pick_shape();
        int r;
        r = $urandom_range(13);
        if (r < 5) return SHAPE_VERSIONS;
        if (r < 10) return SHAPE_KEY;
        if (r == 10) return SHAPE_KEY_SHORT;
        if (r == 11) return SHAPE_KEY_EMPTY;
        if (r == 12) return SHAPE_KEY_ODD;
        return SHAPE_OTHER;
    endfunction

    function automatic void build_hello(input plan_t plan, ref logic [7:0] msg[$]);
        logic [7:0] exts[$];
        ext_shape_t shapes[$];
        int         sid;
        int         declared;
        int         keep;
        int         r;
        bit         magic;
        msg.delete();
        if (plan == PLAN_NOISE || (plan == PLAN_RANDOM && $urandom_range(11) == 0)) begin
            repeat ($urandom_range(1, 12)) msg = {msg, 8'($urandom)};
            return;
        end
        repeat (2) msg = {msg, (($urandom_range(3) == 0) ? 8'($urandom) : 8'h03)};
        magic = (plan == PLAN_FULL) || ($urandom_range(3) == 0);
        for (int i = 0; i < 32; i++) msg = {msg, (magic ? HRR_RANDOM[i] : 8'($urandom))};
        // near miss on the retry pattern
        if (plan == PLAN_RANDOM && magic && $urandom_range(2) == 0)
            msg[2 + $urandom_range(31)] ^= 8'(1 << $urandom_range(7));

        r = $urandom_range(9);
        if (plan == PLAN_FULL) sid = 32;
        else if (plan == PLAN_LONG_SID || (plan == PLAN_RANDOM && r == 2))
            sid = $urandom_range(33, 255);
        else if (r == 0) sid = 0;
        else if (r == 1) sid = 32;
        else sid = $urandom_range(1, 8);
        msg = {msg, 8'(sid)};
        if (sid <= 32) repeat (sid) msg = {msg, 8'($urandom)};
        push16(msg, ($urandom_range(1) == 0) ? 16'h1301 + 16'($urandom_range(2))
                                            : 16'($urandom));
        msg = {msg, (($urandom_range(3) == 0) ? 8'($urandom) : 8'h00)};

        case (plan)
            PLAN_FULL:       shapes = '{SHAPE_VERSIONS, SHAPE_KEY};
            PLAN_SHORT_KEY:  shapes = '{SHAPE_KEY, SHAPE_KEY_SHORT};
            PLAN_EMPTY_KEY:  shapes = '{SHAPE_VERSIONS, SHAPE_KEY_EMPTY};
            PLAN_SHORT_LIST: shapes = '{SHAPE_VERSIONS, SHAPE_KEY, SHAPE_OTHER};
            PLAN_REPEAT:     shapes = '{SHAPE_VERSIONS, SHAPE_KEY, SHAPE_VERSIONS, SHAPE_KEY};
            PLAN_ODD_KEY:    shapes = '{SHAPE_OTHER, SHAPE_KEY_ODD, SHAPE_VERSIONS};
            default:         repeat ($urandom_range(0, 3)) shapes = {shapes, pick_shape()};
        endcase
        foreach (shapes[i]) append_ext(shapes[i], exts);

        declared = exts.size();
        if (plan == PLAN_SHORT_LIST ||
            (plan == PLAN_RANDOM && exts.size() > 1 && $urandom_range(9) == 0))
            declared = $urandom_range(1, exts.size() - 1);
        else if (plan == PLAN_RANDOM && $urandom_range(11) == 0)
            declared = exts.size() + $urandom_range(1, 20);
        else if (plan == PLAN_RANDOM && $urandom_range(15) == 0)
            declared = $urandom_range(65535);
        push16(msg, 16'(declared));
        foreach (exts[i]) msg = {msg, exts[i]};

        if (plan == PLAN_TRAILING || (plan == PLAN_RANDOM && $urandom_range(7) == 0))
            repeat ($urandom_range(1, 4)) msg = {msg, 8'($urandom)};
        if (plan == PLAN_CUT || (plan == PLAN_RANDOM && $urandom_range(9) == 0)) begin
            keep = $urandom_range(1, msg.size() - 1);
            while (msg.size() > keep) void'(msg.pop_back());
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_byte_value <= b;
        s_end_of_message <= last;
        do @(posedge aclk); while (!s_ready);
        sb.take_byte(b, last);
    endtask

    task automatic send_message(input logic [7:0] msg[$]);
        for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
    endtask

    // hold the input off until every due word has come out
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.due_words.size() != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        logic [7:0] msg[$];
        int         sent;
        int         msg_no;
        plan_t      plan;
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // short bodies ending early, byte extremes
        msg.delete();
        msg = {msg, 8'hFF};
        send_message(msg);
        msg.delete();
        msg = {msg, 8'h00};
        send_message(msg);
        msg.delete();
        msg = {msg, 8'h03, 8'h03, 8'hCF, 8'h21};
        send_message(msg);
        msg.delete();
        msg = {msg, 8'h00, 8'hFF, 8'hFF};
        send_message(msg);
        drain();

        sent = 0;
        msg_no = 0;
        while (sent < BYTE_TARGET) begin
            plan = (msg_no < FIXED_PLANS) ? plan_t'(msg_no + 1) : PLAN_RANDOM;
            quiet = (msg_no >= 3 && msg_no < 6);
            build_hello(plan, msg);
            send_message(msg);
            sent += msg.size();
            if ($urandom_range(4) == 0) drain();
            msg_no++;
        end
        quiet = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.mismatch_count == 0 && sb.due_words.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
